// ----- src/dtfb_pkg.sv -----
// Shared types and constants for the depth-tested framebuffer.
`timescale 1ns / 1ps

package dtfb_pkg;

  // Default geometry and depth format
  localparam int unsigned MaxWidthDef  = 512;
  localparam int unsigned MaxHeightDef = 512;
  localparam int unsigned DepthBitsDef = 24;

  // Fixed field widths
  localparam int unsigned CfgW    = 10;
  localparam int unsigned CoordW  = 13;
  localparam int unsigned DepthW  = 24;
  localparam int unsigned TolW    = 24;
  localparam int unsigned ColorW  = 32;
  localparam int unsigned FuncW   = 3;
  localparam int unsigned InDataW = 112;
  localparam int unsigned OutDataW = 8;

  // Reset values of the frame size registers
  localparam logic [CfgW-1:0] FrameWidthRst  = 10'd512;
  localparam logic [CfgW-1:0] FrameHeightRst = 10'd512;

  // Configuration register indexes
  localparam logic CfgFrameWidth  = 1'b0;
  localparam logic CfgFrameHeight = 1'b1;

  // Operation codes carried in tuser
  typedef enum logic [FuncW-1:0] {
    FN_CLEAR            = 3'd0,
    FN_CLEAR_DEPTH      = 3'd1,
    FN_SET_PIXEL        = 3'd2,
    FN_DEPTH_TEST       = 3'd3,
    FN_SET_DEPTH        = 3'd4,
    FN_SET_PIXEL_CLOSER = 3'd5
  } func_e;

  // Control from the sequencer to the pixel store
  typedef struct packed {
    logic depth_re;
    logic depth_we;
    logic color_we;
  } store_ctl_t;

endpackage

// ----- src/dtfb_store.sv -----
// Color and depth memories, one synchronous port each.
`timescale 1ns / 1ps

module dtfb_store #(
  parameter int unsigned Entries   = dtfb_pkg::MaxWidthDef * dtfb_pkg::MaxHeightDef,
  parameter int unsigned AddrW     = 18,
  parameter int unsigned DepthBits = dtfb_pkg::DepthBitsDef
) (
  input  logic                        clk_i,
  input  dtfb_pkg::store_ctl_t        ctl_i,
  input  logic [AddrW-1:0]            addr_i,
  input  logic [dtfb_pkg::ColorW-1:0] color_wdata_i,
  input  logic [DepthBits-1:0]        depth_wdata_i,
  output logic [DepthBits-1:0]        depth_rdata_o
);

  logic [dtfb_pkg::ColorW-1:0] color_mem [Entries];
  logic [DepthBits-1:0]        depth_mem [Entries];
  logic [DepthBits-1:0]        depth_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.color_we) begin
      color_mem[addr_i] <= color_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.depth_we) begin
      depth_mem[addr_i] <= depth_wdata_i;
    end
    if (ctl_i.depth_re) begin
      depth_rdata_q <= depth_mem[addr_i];
    end
  end

  assign depth_rdata_o = depth_rdata_q;

endmodule

// ----- src/depth_tested_framebuffer.sv -----
// Top level of the depth-tested framebuffer: request sequencer and result register.
`timescale 1ns / 1ps

// Z-buffer with a color store and a depth store of MAX_WIDTH*MAX_HEIGHT entries,
// addressed row-major as y*frame_width+x.
// Request channel (s_axis): tuser carries the operation, tdata the pixel fields.
// Result channel (m_axis): one result per request, bit 0 of tdata is the pass flag.
// Config port: cfg_we_i writes frame_width (index 0) or frame_height (index 1);
// write only while idle and follow a resize with a clear.
// A pixel request steps through accept, address multiply, depth read, and
// compare and write back; the single depth memory port sets this.
// Clear and clear-depth walk every entry, one per cycle, with tready low
// meanwhile; the result follows the walk.
// After reset the same walk fills color with zero and depth with infinity
// before tready rises; it produces no result.
// A stalled result register holds; one more request is accepted and waits in its
// final step until the result register frees up.
module depth_tested_framebuffer #(
  parameter int unsigned MAX_WIDTH  = dtfb_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = dtfb_pkg::MaxHeightDef,
  parameter int unsigned DEPTH_BITS = dtfb_pkg::DepthBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pos_x[12:0], pos_y[25:13], depth_value[49:26], depth_finite[50],
  // test_tolerance[74:51], pixel_color[106:75], zero[111:107]
  input  logic [dtfb_pkg::InDataW-1:0]  s_axis_tdata,
  // func[2:0]
  input  logic [dtfb_pkg::FuncW-1:0]    s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // passed[0], zero[7:1]
  output logic [dtfb_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_we_i,
  input  logic                          cfg_addr_i,
  input  logic [dtfb_pkg::CfgW-1:0]     cfg_wdata_i
);

  localparam int unsigned Entries = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW   = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned XW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WW      = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW      = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CW      = dtfb_pkg::CoordW;
  localparam int unsigned SumW    =
      ((DEPTH_BITS > dtfb_pkg::TolW) ? DEPTH_BITS : dtfb_pkg::TolW) + 1;
  localparam logic [DEPTH_BITS-1:0] DepthInf = {DEPTH_BITS{1'b1}};
  localparam logic [AddrW-1:0]      LastAddr = AddrW'(Entries - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_DONE,
    ST_SWEEP
  } state_e;

  state_e                       state_q;
  logic [dtfb_pkg::CfgW-1:0]    cfg_w_q, cfg_h_q;
  logic [WW-1:0]                w_eff;
  logic [HW-1:0]                h_eff;
  logic [dtfb_pkg::FuncW-1:0]   func_q;
  logic [XW-1:0]                ux_q;
  logic [YW-1:0]                uy_q;
  logic [AddrW-1:0]             idx_q;
  logic [AddrW-1:0]             cnt_q;
  logic [DEPTH_BITS-1:0]        depth_q;
  logic [dtfb_pkg::TolW-1:0]    tol_q;
  logic [dtfb_pkg::ColorW-1:0]  color_q;
  logic                         inside_q, ok_q, init_q;
  logic                         m_valid_q, passed_q;

  // Request field views
  logic [CW-1:0]                in_x, in_y;
  logic [dtfb_pkg::DepthW-1:0]  in_depth_raw;
  logic                         in_finite_flag;
  logic [DEPTH_BITS-1:0]        in_depth;
  logic                         in_finite, in_inside;

  logic                         s_accept, out_free, sweeping, closer, pass;
  logic [SumW-1:0]              tol_sum;
  logic [DEPTH_BITS-1:0]        rd_depth;
  logic [AddrW-1:0]             store_addr;
  dtfb_pkg::store_ctl_t         store_ctl;

  assign in_x           = s_axis_tdata[12:0];
  assign in_y           = s_axis_tdata[25:13];
  assign in_depth_raw   = s_axis_tdata[49:26];
  assign in_finite_flag = s_axis_tdata[50];
  assign in_depth       = DEPTH_BITS'(in_depth_raw);
  assign in_finite      = in_finite_flag && (in_depth != DepthInf);

  // Out-of-range sizes act as 1 or as the maximum
  always_comb begin
    if (cfg_w_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_w_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(cfg_h_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_h_q);
    end
  end

  assign in_inside = !in_x[CW-1] && !in_y[CW-1] &&
                     (in_x < CW'(w_eff)) && (in_y < CW'(h_eff));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign sweeping      = (state_q == ST_SWEEP);

  // Compare against the stored depth registered in the read step
  assign tol_sum = SumW'(rd_depth) + SumW'(tol_q);
  assign closer  = ok_q && (depth_q < rd_depth);

  always_comb begin
    case (func_q)
      dtfb_pkg::FN_DEPTH_TEST:
        pass = ok_q && ((rd_depth == DepthInf) || (SumW'(depth_q) <= tol_sum));
      dtfb_pkg::FN_SET_DEPTH,
      dtfb_pkg::FN_SET_PIXEL_CLOSER:
        pass = closer;
      default:
        pass = 1'b0;
    endcase
  end

  always_comb begin
    store_ctl = '0;
    store_ctl.depth_re = (state_q == ST_READ);
    if (sweeping) begin
      store_ctl.depth_we = 1'b1;
      store_ctl.color_we = (func_q == dtfb_pkg::FN_CLEAR);
    end else if (state_q == ST_DONE && out_free) begin
      case (func_q)
        dtfb_pkg::FN_SET_PIXEL: begin
          store_ctl.color_we = inside_q;
        end
        dtfb_pkg::FN_SET_DEPTH: begin
          store_ctl.depth_we = closer;
        end
        dtfb_pkg::FN_SET_PIXEL_CLOSER: begin
          store_ctl.depth_we = closer;
          store_ctl.color_we = closer;
        end
        default: begin
          store_ctl.depth_we = 1'b0;
        end
      endcase
    end
  end

  assign store_addr = sweeping ? cnt_q : idx_q;

  dtfb_store #(
    .Entries  (Entries),
    .AddrW    (AddrW),
    .DepthBits(DEPTH_BITS)
  ) u_store (
    .clk_i        (clk_i),
    .ctl_i        (store_ctl),
    .addr_i       (store_addr),
    .color_wdata_i(color_q),
    .depth_wdata_i(depth_q),
    .depth_rdata_o(rd_depth)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= dtfb_pkg::FrameWidthRst;
      cfg_h_q <= dtfb_pkg::FrameHeightRst;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == dtfb_pkg::CfgFrameWidth) begin
        cfg_w_q <= cfg_wdata_i;
      end else begin
        cfg_h_q <= cfg_wdata_i;
      end
    end
  end

  // Sequencer; reset starts with a sweep that fills color 0 and depth infinity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_SWEEP;
      func_q    <= dtfb_pkg::FN_CLEAR;
      depth_q   <= DepthInf;
      color_q   <= '0;
      cnt_q     <= '0;
      init_q    <= 1'b1;
      m_valid_q <= 1'b0;
      passed_q  <= 1'b0;
    end else begin
      if (state_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_accept) begin
            func_q   <= s_axis_tuser;
            ux_q     <= XW'(in_x);
            uy_q     <= YW'(in_y);
            tol_q    <= s_axis_tdata[74:51];
            inside_q <= in_inside;
            ok_q     <= in_inside && in_finite;
            cnt_q    <= '0;
            if (s_axis_tuser == dtfb_pkg::FN_CLEAR) begin
              color_q <= s_axis_tdata[106:75];
              depth_q <= DepthInf;
              state_q <= ST_SWEEP;
            end else if (s_axis_tuser == dtfb_pkg::FN_CLEAR_DEPTH) begin
              depth_q <= in_finite_flag ? in_depth : DepthInf;
              state_q <= ST_SWEEP;
            end else begin
              color_q <= s_axis_tdata[106:75];
              depth_q <= in_depth;
              state_q <= ST_CALC;
            end
          end
        end
        ST_CALC: begin
          // Only meaningful when inside; the product then stays below Entries
          idx_q   <= AddrW'(uy_q) * AddrW'(w_eff) + AddrW'(ux_q);
          state_q <= ST_READ;
        end
        ST_READ: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            passed_q <= pass;
            state_q  <= ST_IDLE;
          end
        end
        ST_SWEEP: begin
          cnt_q <= cnt_q + AddrW'(1);
          if (cnt_q == LastAddr) begin
            init_q  <= 1'b0;
            state_q <= init_q ? ST_IDLE : ST_DONE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(dtfb_pkg::OutDataW - 1){1'b0}}, passed_q};

`ifndef SYNTHESIS
  // A conditional depth write only ever lowers the stored depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (store_ctl.depth_we && !sweeping) |-> (depth_q < rd_depth))
    else $error("depth write does not lower stored depth");

  // Pixel accesses stay within the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((store_ctl.color_we || store_ctl.depth_we) && !sweeping) |->
      (32'(idx_q) < 32'(Entries)))
    else $error("pixel address beyond store");

  // A new result is loaded only from the final step of a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result without a finished request");

  // The reset fill never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> !m_valid_q)
    else $error("result during reset fill");

  // Clears always answer 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && (func_q == dtfb_pkg::FN_CLEAR ||
      func_q == dtfb_pkg::FN_CLEAR_DEPTH)) |-> !pass)
    else $error("clear reported pass");
`endif

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the depth-tested framebuffer: directed and random requests.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned FuncW    = dtfb_pkg::FuncW;
  localparam int unsigned CoordW   = dtfb_pkg::CoordW;
  localparam int unsigned DepthW   = dtfb_pkg::DepthW;
  localparam int unsigned TolW     = dtfb_pkg::TolW;
  localparam int unsigned ColorW   = dtfb_pkg::ColorW;
  localparam int unsigned InDataW  = dtfb_pkg::InDataW;
  localparam int unsigned OutDataW = dtfb_pkg::OutDataW;
  localparam int unsigned CfgW     = dtfb_pkg::CfgW;

  localparam int unsigned StoreSize = dtfb_pkg::MaxWidthDef * dtfb_pkg::MaxHeightDef;
  localparam logic [DepthW-1:0] DepthInf = '1;
  localparam logic [FuncW-1:0] OpSpare0 = 3'd6;
  localparam logic [FuncW-1:0] OpSpare1 = 3'd7;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    logic [FuncW-1:0]  op;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [DepthW-1:0] z;
    logic              z_ok;
    logic [TolW-1:0]   tol;
    logic [ColorW-1:0] color;
  } frag_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [FuncW-1:0]    s_tuser = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic                cfg_we = 1'b0;
  logic                cfg_addr = 1'b0;
  logic [CfgW-1:0]     cfg_wdata = '0;

  // Predicted state. Color never reaches the result port, so only depth is kept.
  logic [DepthW-1:0] zbuf [StoreSize];
  logic [CfgW-1:0]   frame_w;
  logic [CfgW-1:0]   frame_h;

  bit pass_flags_q [$];
  int unsigned err_cnt = 0;
  int unsigned results_seen = 0;
  bit src_burst = 1'b0;
  bit sink_burst = 1'b0;
  bit hold_req = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  depth_tested_framebuffer u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata)
  );

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    err_cnt++;
  endtask

  // 0 acts as 1, anything past the maximum acts as the maximum
  function automatic int unsigned eff_dim(input logic [CfgW-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  function automatic bit predict_pass(input frag_t f);
    int unsigned w, h, idx;
    bit hit, z_ok, pass;
    logic [DepthW-1:0] stored;
    w = eff_dim(frame_w, dtfb_pkg::MaxWidthDef);
    h = eff_dim(frame_h, dtfb_pkg::MaxHeightDef);
    hit = !f.x[CoordW-1] && !f.y[CoordW-1] && f.x < w && f.y < h;
    idx = hit ? (f.y * w + f.x) % StoreSize : 0;
    z_ok = f.z_ok && (f.z != DepthInf);
    pass = 1'b0;
    case (f.op)
      dtfb_pkg::FN_CLEAR: begin
        foreach (zbuf[i]) zbuf[i] = DepthInf;
      end
      dtfb_pkg::FN_CLEAR_DEPTH: begin
        foreach (zbuf[i]) zbuf[i] = f.z_ok ? f.z : DepthInf;
      end
      dtfb_pkg::FN_DEPTH_TEST: begin
        if (hit && z_ok) begin
          stored = zbuf[idx];
          // stored + tolerance is formed one bit wider so it cannot wrap
          pass = (stored == DepthInf) ||
                 ({1'b0, f.z} <= {1'b0, stored} + {1'b0, f.tol});
        end
      end
      dtfb_pkg::FN_SET_DEPTH, dtfb_pkg::FN_SET_PIXEL_CLOSER: begin
        if (hit && z_ok && f.z < zbuf[idx]) begin
          zbuf[idx] = f.z;
          pass = 1'b1;
        end
      end
      default: ;
    endcase
    return pass;
  endfunction

  function automatic frag_t mk(input logic [FuncW-1:0] op, input int x, input int y,
                               input int z, input bit z_ok, input int tol,
                               input logic [ColorW-1:0] color);
    frag_t f;
    f.op = op;
    f.x = x[CoordW-1:0];
    f.y = y[CoordW-1:0];
    f.z = z[DepthW-1:0];
    f.z_ok = z_ok;
    f.tol = tol[TolW-1:0];
    f.color = color;
    return f;
  endfunction

  // Mostly in-frame fragments with depths clustered so hits and misses both occur
  function automatic frag_t rand_frag();
    frag_t f;
    int unsigned w, h, pick;
    w = eff_dim(frame_w, dtfb_pkg::MaxWidthDef);
    h = eff_dim(frame_h, dtfb_pkg::MaxHeightDef);
    pick = $urandom_range(0, 99);
    if (pick < 2) f.op = pick[0] ? OpSpare1 : OpSpare0;
    else if (pick < 17) f.op = dtfb_pkg::FN_SET_PIXEL;
    else if (pick < 50) f.op = dtfb_pkg::FN_DEPTH_TEST;
    else if (pick < 75) f.op = dtfb_pkg::FN_SET_DEPTH;
    else f.op = dtfb_pkg::FN_SET_PIXEL_CLOSER;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      f.x = CoordW'($urandom_range(0, w - 1));
      f.y = CoordW'($urandom_range(0, h - 1));
    end else if (pick < 92) begin
      f.x = CoordW'($urandom);
      f.y = CoordW'($urandom);
    end else if (pick < 96) begin
      f.x = CoordW'(w);
      f.y = CoordW'($urandom_range(0, h - 1));
    end else begin
      f.x = CoordW'($urandom_range(0, w - 1));
      f.y = CoordW'(h);
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) f.z = DepthW'($urandom_range(0, 255));
    else if (pick < 65) f.z = DepthW'($urandom_range('h7FFF00, 'h800100));
    else if (pick < 85) f.z = DepthW'($urandom);
    else if (pick < 90) f.z = DepthInf;
    else f.z = DepthW'(pick[0]);
    pick = $urandom_range(0, 99);
    if (pick < 50) f.tol = '0;
    else if (pick < 80) f.tol = TolW'($urandom_range(0, 255));
    else f.tol = TolW'($urandom);
    f.z_ok = ($urandom_range(0, 99) < 92);
    f.color = $urandom;
    return f;
  endfunction

  task automatic send_frag(input frag_t f);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f.op;
    s_tdata  <= {5'b0, f.color, f.tol, f.z_ok, f.z, f.y, f.x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pass_flags_q.push_back(predict_pass(f));
  endtask

  task automatic run_random(input int unsigned n);
    repeat (n) send_frag(rand_frag());
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pass_flags_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Resize only while idle; both registers go in back to back
  task automatic set_frame(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= dtfb_pkg::CfgFrameWidth;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_addr  <= dtfb_pkg::CfgFrameHeight;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    frame_w = w;
    frame_h = h;
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_frag(mk(dtfb_pkg::FN_SET_PIXEL, 0, 0, 0, 1, 0, '1));
    send_frag(mk(dtfb_pkg::FN_DEPTH_TEST, 0, 0, 0, 1, 0, '0));       // empty pixel passes
    send_frag(mk(dtfb_pkg::FN_SET_DEPTH, 0, 0, 100, 1, 0, '0));
    send_frag(mk(dtfb_pkg::FN_SET_DEPTH, 0, 0, 100, 1, 0, '0));      // equal, not closer
    send_frag(mk(dtfb_pkg::FN_DEPTH_TEST, 0, 0, 100, 1, 0, '0));
    send_frag(mk(dtfb_pkg::FN_DEPTH_TEST, 0, 0, 101, 1, 0, '0));
    send_frag(mk(dtfb_pkg::FN_DEPTH_TEST, 0, 0, 'hFFFFFE, 1, 'hFFFFFF, '0));  // sum carries
    send_frag(mk(dtfb_pkg::FN_SET_PIXEL_CLOSER, 511, 511, 'hFFFFFE, 1, 0, '0));
    send_frag(mk(dtfb_pkg::FN_SET_PIXEL_CLOSER, 511, 511, 0, 1, 0, '1));
    send_frag(mk(dtfb_pkg::FN_SET_PIXEL_CLOSER, 511, 511, 0, 1, 0, '1));
    send_frag(mk(dtfb_pkg::FN_DEPTH_TEST, 512, 0, 0, 1, 0, '0));
    send_frag(mk(dtfb_pkg::FN_DEPTH_TEST, 0, 512, 0, 1, 0, '0));
    send_frag(mk(dtfb_pkg::FN_SET_DEPTH, -1, 0, 0, 1, 0, '0));
    send_frag(mk(dtfb_pkg::FN_SET_DEPTH, 0, -4096, 0, 1, 0, '0));
    send_frag(mk(dtfb_pkg::FN_DEPTH_TEST, 4095, 4095, 0, 1, 0, '0));
    send_frag(mk(dtfb_pkg::FN_DEPTH_TEST, -4096, -1, 0, 1, 0, '0));
    // all-ones depth counts as non-finite even with the flag set
    send_frag(mk(dtfb_pkg::FN_DEPTH_TEST, 1, 1, int'(DepthInf), 1, 0, '0));
    send_frag(mk(dtfb_pkg::FN_SET_DEPTH, 1, 1, int'(DepthInf), 1, 0, '0));
    send_frag(mk(dtfb_pkg::FN_SET_DEPTH, 1, 1, 50, 0, 0, '0));
    send_frag(mk(dtfb_pkg::FN_DEPTH_TEST, 1, 1, 50, 1, 0, '0));
    send_frag(mk(dtfb_pkg::FN_SET_PIXEL, -1, -1, 0, 1, 0, '1));
    send_frag(mk(OpSpare0, 0, 0, 0, 1, 'hFFFFFF, '1));
    send_frag(mk(OpSpare1, 0, 0, 0, 1, 'hFFFFFF, '1));
  endtask

  // Resizes without clearing, register extremes included
  task automatic test_geometry();
    set_frame(10'd0, 10'd0);
    run_random(100);
    set_frame(10'd1, 10'd512);
    run_random(120);
    set_frame(10'd512, 10'd1);
    run_random(120);
    set_frame(10'd8, 10'd8);
    run_random(200);
    set_frame(10'd3, 10'd17);
    run_random(150);
    set_frame(10'd1023, 10'd1023);
    run_random(150);
    set_frame(CfgW'($urandom_range(1, 40)), CfgW'($urandom_range(1, 40)));
    run_random(150);
    set_frame(10'd512, 10'd512);
    run_random(60);
  endtask

  task automatic test_clear_depth();
    set_frame(10'd16, 10'd16);
    send_frag(mk(dtfb_pkg::FN_CLEAR_DEPTH, $urandom, $urandom, 'h7FFFF0, 1, $urandom,
                 $urandom));
    run_random(150);
  endtask

  task automatic test_backpressure();
    set_frame(10'd4, 10'd4);
    // sink stops for a long stretch while requests keep coming
    hold_req = 1'b1;
    src_burst = 1'b1;
    run_random(40);
    sink_burst = 1'b1;
    run_random(100);
    src_burst = 1'b0;
    sink_burst = 1'b0;
  endtask

  task automatic test_clear_all();
    set_frame(10'd24, 10'd10);
    send_frag(mk(dtfb_pkg::FN_CLEAR, $urandom, $urandom, $urandom, 1, $urandom, $urandom));
    run_random(100);
    // flag clear: depth store returns to infinity whatever the value
    send_frag(mk(dtfb_pkg::FN_CLEAR_DEPTH, $urandom, $urandom, 5, 0, $urandom, $urandom));
    run_random(100);
  endtask

  initial begin : result_sink
    int unsigned stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      stall = sink_burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    logic want;
    if (m_tvalid && m_tready) begin
      if (pass_flags_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with no request outstanding", results_seen));
      end else begin
        want = pass_flags_q.pop_front();
        if (m_tdata[0] !== want)
          report_mismatch($sformatf("result %0d: passed %b, want %b",
                                    results_seen, m_tdata[0], want));
      end
      results_seen++;
    end
  end

  initial begin : stimulus
    foreach (zbuf[i]) zbuf[i] = DepthInf;
    frame_w = dtfb_pkg::FrameWidthRst;
    frame_h = dtfb_pkg::FrameHeightRst;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // wait out the store initialization walk
    while (!s_tready) @(posedge clk);
    test_directed();
    test_geometry();
    test_clear_depth();
    test_backpressure();
    test_clear_all();
    drain();
    repeat (16) @(posedge clk);
    if (err_cnt == 0 && pass_flags_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
